[sv/utf8_accent_fold_to_ascii_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the UTF-8 accent folding block
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef UTF8_ACCENT_FOLD_TO_ASCII_ASSERT_SVH
`define UTF8_ACCENT_FOLD_TO_ASCII_ASSERT_SVH

// Generic property check, sampled on the rising clock and off during reset.
`define UAFA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("uafa: assertion failed");

// Property check with its own message text.
`define UAFA_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

[sv/uafa_pkg.sv]
// ----------------------------------------------------------------------------
// uafa_pkg
// Shared types and the second-byte folding table of the UTF-8 folding block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uafa_pkg;

  localparam int unsigned CountW = 10;
  localparam int unsigned CharW  = 7;

  localparam logic [7:0] ByteTerm  = 8'h00;
  localparam logic [7:0] ByteAscii = 8'h80;
  localparam logic [7:0] ByteLeadC = 8'hC3;
  localparam logic [7:0] ByteLeadE = 8'hE2;
  localparam logic [7:0] ByteCont  = 8'h80;
  localparam logic [7:0] ByteEllip = 8'hA6;

  localparam logic [CharW-1:0] ChQuest = 7'h3F;
  localparam logic [CharW-1:0] ChDash  = 7'h2D;
  localparam logic [CharW-1:0] ChDot   = 7'h2E;

  localparam logic [CountW-1:0] LimitReset = 10'd1023;

  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic              char_valid;
    logic              last;
    logic [CountW-1:0] length;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } push_t;

  // Folds the byte after C3 to its base Latin letter.
  function automatic logic [CharW-1:0] fold_second(input logic [7:0] b);
    logic [CharW-1:0] ch;
    ch = ChQuest;
    case (b) inside
      [8'h80:8'h83]: ch = 7'h41;
      8'h87:         ch = 7'h43;
      [8'h89:8'h8A]: ch = 7'h45;
      8'h8D:         ch = 7'h49;
      [8'h93:8'h95]: ch = 7'h4F;
      8'h9A:         ch = 7'h55;
      [8'hA0:8'hA3]: ch = 7'h61;
      8'hA7:         ch = 7'h63;
      [8'hA9:8'hAA]: ch = 7'h65;
      8'hAD:         ch = 7'h69;
      [8'hB3:8'hB5]: ch = 7'h6F;
      8'hBA:         ch = 7'h75;
      default:       ch = ChQuest;
    endcase
    return ch;
  endfunction

endpackage

[sv/uafa_decode.sv]
// ----------------------------------------------------------------------------
// uafa_decode
// Input byte register, sequence state, character limit and one-pass decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uafa_decode #(
  parameter int unsigned MAX_CHARS = 1023
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uafa_pkg::CountW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          room_i,
  output logic                          push_o,
  output uafa_pkg::push_t               push_data_o
);

  localparam logic [uafa_pkg::CountW-1:0] LimCap =
    (MAX_CHARS > 1023) ? 10'd1023 : uafa_pkg::CountW'(MAX_CHARS);

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_C3    = 2'd1,
    MODE_E2    = 2'd2,
    MODE_E2_80 = 2'd3
  } mode_e;

  logic                        byte_vld_q;
  logic [7:0]                  byte_q;
  mode_e                       mode_q, mode_d;
  logic [uafa_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [uafa_pkg::CountW-1:0] limit_q;
  logic [uafa_pkg::CountW-1:0] lim;
  logic                        adv;

  assign lim        = (limit_q > LimCap) ? LimCap : limit_q;
  assign adv        = byte_vld_q & room_i;
  assign in_stall_o = byte_vld_q & ~room_i;
  assign push_o     = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
      mode_q     <= MODE_NONE;
      cnt_q      <= '0;
      limit_q    <= uafa_pkg::LimitReset;
    end else begin
      if (!in_stall_o) begin
        byte_vld_q <= in_valid_i;
      end
      if (adv) begin
        mode_q <= mode_d;
        cnt_q  <= cnt_d;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  // A pending sequence may first flush one character, then the byte is
  // treated as a fresh lead byte, which may give a second result.
  always_comb begin
    logic                        emit1, fresh, is_term, fresh_emit, w1, w2;
    logic [uafa_pkg::CharW-1:0]  ch1, ch2;
    logic [uafa_pkg::CountW-1:0] cnt1, cnt2;
    uafa_pkg::result_t           r1, r2;

    emit1   = 1'b0;
    ch1     = uafa_pkg::ChQuest;
    is_term = (byte_q == uafa_pkg::ByteTerm);
    fresh   = 1'b0;
    mode_d  = MODE_NONE;

    case (mode_q)
      MODE_C3: begin
        emit1 = 1'b1;
        ch1   = is_term ? uafa_pkg::ChQuest : uafa_pkg::fold_second(byte_q);
        fresh = is_term;
      end
      MODE_E2: begin
        if (byte_q == uafa_pkg::ByteCont) begin
          mode_d = MODE_E2_80;
        end else begin
          emit1 = 1'b1;
          ch1   = uafa_pkg::ChQuest;
          fresh = 1'b1;
        end
      end
      MODE_E2_80: begin
        emit1 = 1'b1;
        ch1   = (byte_q == uafa_pkg::ByteEllip) ? uafa_pkg::ChDot : uafa_pkg::ChDash;
        fresh = is_term;
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    fresh_emit = 1'b0;
    ch2        = byte_q[uafa_pkg::CharW-1:0];
    if (fresh && !is_term) begin
      if (byte_q < uafa_pkg::ByteAscii) begin
        fresh_emit = 1'b1;
      end else if (byte_q == uafa_pkg::ByteLeadC) begin
        mode_d = MODE_C3;
      end else if (byte_q == uafa_pkg::ByteLeadE) begin
        mode_d = MODE_E2;
      end else begin
        fresh_emit = 1'b1;
        ch2        = uafa_pkg::ChQuest;
      end
    end

    w1   = emit1 & (cnt_q < lim);
    cnt1 = cnt_q + uafa_pkg::CountW'(w1);
    w2   = fresh_emit & (cnt1 < lim);
    cnt2 = cnt1 + uafa_pkg::CountW'(w2);
    cnt_d = (fresh && is_term) ? '0 : cnt2;

    r1 = '{ch: ch1, char_valid: 1'b1, last: 1'b0, length: cnt1};
    if (fresh && is_term) begin
      r2 = '{ch: '0, char_valid: 1'b0, last: 1'b1, length: cnt1};
    end else begin
      r2 = '{ch: ch2, char_valid: 1'b1, last: 1'b0, length: cnt2};
    end

    push_data_o.num  = {1'b0, w1} + {1'b0, (w2 | (fresh & is_term))};
    push_data_o.res0 = w1 ? r1 : r2;
    push_data_o.res1 = r2;
  end

endmodule

[sv/uafa_res_fifo.sv]
// ----------------------------------------------------------------------------
// uafa_res_fifo
// Four-entry result queue taking up to two results per cycle, one out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uafa_res_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  uafa_pkg::push_t   push_data_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output uafa_pkg::result_t out_data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  uafa_pkg::result_t entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     cnt_q;
  logic [1:0]        num;
  logic              pop;

  assign num         = push_i ? push_data_i.num : 2'd0;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o & ~out_stall_i;
  assign out_data_o  = entry_q[rd_ptr_q];
  // Room is judged without the same-cycle pop so it never waits on the stall.
  assign room_o      = (cnt_q <= (PtrW+1)'(Depth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(num);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_q + (PtrW+1)'(num) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (num != 2'd0) begin
      entry_q[wr_ptr_q] <= push_data_i.res0;
    end
    if (num == 2'd2) begin
      entry_q[wr_ptr_q + PtrW'(1)] <= push_data_i.res1;
    end
  end

endmodule

[sv/utf8_accent_fold_to_ascii.sv]
// ----------------------------------------------------------------------------
// utf8_accent_fold_to_ascii
// Folds a zero-terminated UTF-8 byte stream to plain ASCII characters.
// ----------------------------------------------------------------------------
// The input channel takes one byte per request (in_valid_i / in_stall_o); a
// zero byte ends the text. The output channel (out_valid_o / out_stall_i)
// gives one result per request: a folded character, or the final result
// marked last that carries the count of characters written in the text.
// Each byte is held in an input register, decoded in one pass and written
// into a four-entry result queue, whose head is offered on the output. One
// byte can be taken in every cycle while in_stall_o is low; a byte that
// causes two results writes both into the queue at once, and the sustained
// rate is set by the output side at one result per cycle when not stalled.
// When the receiver stalls, the queue fills and in_stall_o rises while a
// byte waits in the input register and fewer than two entries are free; a
// stalled result holds steady.
// Reset empties the queue, clears the pending sequence and the count, and
// sets the character limit to 1023. cfg_we_i writes the limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_accent_fold_to_ascii #(
  parameter int unsigned MAX_CHARS = 1023
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [uafa_pkg::CountW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  in_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [uafa_pkg::CharW-1:0]  out_char_o,
  output logic                        out_char_valid_o,
  output logic                        out_last_o,
  output logic [uafa_pkg::CountW-1:0] out_text_length_o
);

  logic              room;
  logic              push;
  uafa_pkg::push_t   push_data;
  uafa_pkg::result_t head;

  uafa_decode #(
    .MAX_CHARS(MAX_CHARS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .room_i      (room),
    .push_o      (push),
    .push_data_o (push_data)
  );

  uafa_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (head)
  );

  assign out_char_o        = head.ch;
  assign out_char_valid_o  = head.char_valid;
  assign out_last_o        = head.last;
  assign out_text_length_o = head.length;

endmodule

[sv/uafa_checker.sv]
// ----------------------------------------------------------------------------
// uafa_checker
// Port-level checks of the folding block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_accent_fold_to_ascii_assert.svh"

module uafa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [uafa_pkg::CharW-1:0]  out_char_o,
  input logic                        out_char_valid_o,
  input logic                        out_last_o,
  input logic [uafa_pkg::CountW-1:0] out_text_length_o
);

  // A stalled result is not withdrawn.
  `UAFA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)

  // Every result is either a character or the end-of-text result, never both.
  `UAFA_ASSERT_MSG(a_kind, clk_i, rst_ni, out_valid_o |-> (out_char_valid_o != out_last_o), "uafa: result kind is ambiguous")

  // The end-of-text result carries no character.
  `UAFA_ASSERT(a_last_blank, clk_i, rst_ni, out_valid_o && out_last_o |-> out_char_o == '0)

  // A written character is always counted, so its length is at least one.
  `UAFA_ASSERT_MSG(a_char_counted, clk_i, rst_ni, out_valid_o && out_char_valid_o |-> out_text_length_o != '0, "uafa: character with zero length")

endmodule

bind utf8_accent_fold_to_ascii uafa_checker u_uafa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .out_char_o        (out_char_o),
  .out_char_valid_o  (out_char_valid_o),
  .out_last_o        (out_last_o),
  .out_text_length_o (out_text_length_o)
);

[sim/utf8_accent_fold_to_ascii_tb.sv]
// ----------------------------------------------------------------------------
// utf8_accent_fold_to_ascii_tb
// Self-checking bench for the UTF-8 to ASCII folding block. It sends
// zero-terminated texts of ASCII bytes, accented Latin pairs, dash and
// ellipsis triples and broken sequences under several character limits.
// A behavioral copy of the folding predicts each result, and a monitor
// compares every result field by field while both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_accent_fold_to_ascii_tb;

  localparam int unsigned FoldMaxChars = 1023;
  localparam int unsigned PipeSettle   = 6;
  localparam int unsigned RunLimit     = 600000;

  typedef enum logic [1:0] {
    SEQ_NONE,
    SEQ_AFTER_C3,
    SEQ_AFTER_E2,
    SEQ_AFTER_E280
  } seq_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [uafa_pkg::CountW-1:0] cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [7:0]                  in_byte_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [uafa_pkg::CharW-1:0]  out_char_o;
  logic                        out_char_valid_o;
  logic                        out_last_o;
  logic [uafa_pkg::CountW-1:0] out_text_length_o;

  // Predictor state.
  seq_e                        seq_state = SEQ_NONE;
  logic [uafa_pkg::CountW-1:0] chars_written = '0;
  logic [uafa_pkg::CountW-1:0] char_limit = uafa_pkg::LimitReset;
  uafa_pkg::result_t           fold_expected[$];

  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned sent_count = 0;
  int unsigned texts_done = 0;
  int unsigned checked_count = 0;

  utf8_accent_fold_to_ascii #(
    .MAX_CHARS(FoldMaxChars)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_char_o       (out_char_o),
    .out_char_valid_o (out_char_valid_o),
    .out_last_o       (out_last_o),
    .out_text_length_o(out_text_length_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RunLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stalls come in bursts of random length while idling is on.
  always @(posedge clk_i) begin
    if (!rst_ni || !idle_on) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 15);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : result_check
    uafa_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fold_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result char=%02h last=%0b len=%0d",
                                  out_char_o, out_last_o, out_text_length_o));
      end else begin
        want = fold_expected.pop_front();
        checked_count++;
        if (out_char_o !== want.ch)
          report_mismatch($sformatf("char %02h, want %02h", out_char_o, want.ch));
        if (out_char_valid_o !== want.char_valid)
          report_mismatch($sformatf("char_valid %0b, want %0b", out_char_valid_o,
                                    want.char_valid));
        if (out_last_o !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last_o, want.last));
        if (out_text_length_o !== want.length)
          report_mismatch($sformatf("text_length %0d, want %0d", out_text_length_o,
                                    want.length));
      end
    end
  end

  // Base letter of a C3 second byte; the lower-case block sits 0x20 above.
  function automatic logic [uafa_pkg::CharW-1:0] latin_base_letter(input logic [7:0] b);
    logic [uafa_pkg::CharW-1:0] base;
    base = uafa_pkg::ChQuest;
    if (b[7:6] == 2'b10) begin
      case (b[4:0])
        5'h00, 5'h01, 5'h02, 5'h03: base = 7'h41;
        5'h07:                      base = 7'h43;
        5'h09, 5'h0A:               base = 7'h45;
        5'h0D:                      base = 7'h49;
        5'h13, 5'h14, 5'h15:        base = 7'h4F;
        5'h1A:                      base = 7'h55;
        default:                    base = uafa_pkg::ChQuest;
      endcase
      if (base != uafa_pkg::ChQuest && b[5]) base = base | 7'h20;
    end
    return base;
  endfunction

  function automatic void add_char(input logic [uafa_pkg::CharW-1:0] ch);
    uafa_pkg::result_t r;
    if (chars_written < char_limit) begin
      chars_written = chars_written + 1'b1;
      r.ch = ch;
      r.char_valid = 1'b1;
      r.last = 1'b0;
      r.length = chars_written;
      fold_expected.push_back(r);
    end
  endfunction

  function automatic void take_lead_byte(input logic [7:0] b);
    uafa_pkg::result_t r;
    if (b == uafa_pkg::ByteTerm) begin
      r.ch = '0;
      r.char_valid = 1'b0;
      r.last = 1'b1;
      r.length = chars_written;
      fold_expected.push_back(r);
      chars_written = '0;
      seq_state = SEQ_NONE;
      texts_done++;
    end else if (b < uafa_pkg::ByteAscii) begin
      add_char(b[uafa_pkg::CharW-1:0]);
    end else if (b == uafa_pkg::ByteLeadC) begin
      seq_state = SEQ_AFTER_C3;
    end else if (b == uafa_pkg::ByteLeadE) begin
      seq_state = SEQ_AFTER_E2;
    end else begin
      add_char(uafa_pkg::ChQuest);
    end
  endfunction

  function automatic void predict_fold(input logic [7:0] b);
    seq_e mode;
    mode = seq_state;
    seq_state = SEQ_NONE;
    case (mode)
      SEQ_AFTER_C3: begin
        if (b == uafa_pkg::ByteTerm) begin
          add_char(uafa_pkg::ChQuest);
          take_lead_byte(b);
        end else begin
          add_char(latin_base_letter(b));
        end
      end
      SEQ_AFTER_E2: begin
        if (b == uafa_pkg::ByteCont) begin
          seq_state = SEQ_AFTER_E280;
        end else begin
          // The byte that broke the sequence starts over as a lead byte.
          add_char(uafa_pkg::ChQuest);
          take_lead_byte(b);
        end
      end
      SEQ_AFTER_E280: begin
        if (b == uafa_pkg::ByteTerm) begin
          add_char(uafa_pkg::ChDash);
          take_lead_byte(b);
        end else begin
          add_char((b == uafa_pkg::ByteEllip) ? uafa_pkg::ChDot : uafa_pkg::ChDash);
        end
      end
      default: take_lead_byte(b);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_fold(b);
    sent_count++;
  endtask

  // Stops sending until every request has drained through the block.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (fold_expected.size() != 0) @(posedge clk_i);
    repeat (PipeSettle) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [uafa_pkg::CountW-1:0] value);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    char_limit = (value > FoldMaxChars) ? uafa_pkg::CountW'(FoldMaxChars) : value;
  endtask

  task automatic send_random_text(input int unsigned max_pieces);
    int unsigned pieces;
    int unsigned kind;
    pieces = $urandom_range(0, max_pieces);
    for (int unsigned p = 0; p < pieces; p++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_byte(8'($urandom_range(1, 127)));
      end else if (kind < 60) begin
        send_byte(uafa_pkg::ByteLeadC);
        if ($urandom_range(0, 4) != 0) send_byte(8'($urandom_range(8'h80, 8'hBF)));
        else send_byte(8'($urandom_range(1, 255)));
      end else if (kind < 72) begin
        send_byte(uafa_pkg::ByteLeadE);
        send_byte(uafa_pkg::ByteCont);
        if ($urandom_range(0, 1) != 0) send_byte(uafa_pkg::ByteEllip);
        else send_byte(8'($urandom_range(1, 255)));
      end else if (kind < 80) begin
        send_byte(uafa_pkg::ByteLeadE);
        send_byte(8'($urandom_range(1, 255)));
      end else if (kind < 86) begin
        send_byte(8'($urandom_range(8'h80, 8'hFF)));
      end else if (kind < 90) begin
        // Sequence cut short by the terminator.
        case ($urandom_range(0, 2))
          0: send_byte(uafa_pkg::ByteLeadC);
          1: send_byte(uafa_pkg::ByteLeadE);
          default: begin
            send_byte(uafa_pkg::ByteLeadE);
            send_byte(uafa_pkg::ByteCont);
          end
        endcase
        break;
      end else begin
        send_byte(8'($urandom_range(1, 255)));
      end
      if ($urandom_range(0, 299) == 0) settle_idle();
    end
    send_byte(uafa_pkg::ByteTerm);
  endtask

  task automatic test_plain_bytes();
    send_byte(uafa_pkg::ByteTerm);
    send_byte(8'h01); send_byte(8'h7F); send_byte(8'h55); send_byte(8'h2A);
    send_byte(uafa_pkg::ByteTerm);
  endtask

  task automatic test_accent_folds();
    send_byte(uafa_pkg::ByteLeadC); send_byte(8'h81);
    send_byte(uafa_pkg::ByteLeadC); send_byte(8'hBA);
    send_byte(uafa_pkg::ByteLeadC); send_byte(8'h41);
    send_byte(uafa_pkg::ByteLeadC); send_byte(8'hFF);
    send_byte(uafa_pkg::ByteTerm);
  endtask

  task automatic test_dash_sequences();
    send_byte(uafa_pkg::ByteLeadE); send_byte(uafa_pkg::ByteCont);
    send_byte(uafa_pkg::ByteEllip);
    send_byte(uafa_pkg::ByteLeadE); send_byte(uafa_pkg::ByteCont); send_byte(8'h94);
    send_byte(uafa_pkg::ByteLeadE); send_byte(8'h41);
    send_byte(uafa_pkg::ByteLeadE); send_byte(uafa_pkg::ByteLeadE);
    send_byte(uafa_pkg::ByteCont); send_byte(uafa_pkg::ByteCont);
    send_byte(uafa_pkg::ByteTerm);
  endtask

  task automatic test_cut_sequences();
    send_byte(uafa_pkg::ByteLeadC); send_byte(uafa_pkg::ByteTerm);
    send_byte(uafa_pkg::ByteLeadE); send_byte(uafa_pkg::ByteTerm);
    send_byte(uafa_pkg::ByteLeadE); send_byte(uafa_pkg::ByteCont);
    send_byte(uafa_pkg::ByteTerm);
    send_byte(8'hFF); send_byte(8'h80); send_byte(uafa_pkg::ByteTerm);
  endtask

  task automatic test_char_limit();
    // With no room every character is dropped, the flushed dash too.
    write_limit('0);
    send_byte(8'h41); send_byte(8'h42);
    send_byte(uafa_pkg::ByteLeadE); send_byte(uafa_pkg::ByteCont);
    send_byte(uafa_pkg::ByteTerm);
    write_limit(10'd1);
    send_byte(8'h78); send_byte(uafa_pkg::ByteLeadC); send_byte(8'h81);
    send_byte(uafa_pkg::ByteTerm);
  endtask

  task automatic test_random_texts(input int unsigned target);
    int unsigned stop_at;
    stop_at = sent_count + target;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 3) == 0) write_limit(uafa_pkg::CountW'($urandom_range(0, 1023)));
      else write_limit(uafa_pkg::CountW'($urandom_range(0, 12)));
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 6)) send_random_text(24);
    end
  endtask

  task automatic test_long_text();
    idle_on = 1'b0;
    write_limit(10'd200);
    repeat (210) send_byte(8'($urandom_range(1, 127)));
    send_byte(uafa_pkg::ByteLeadC); send_byte(8'hA9);
    send_byte(uafa_pkg::ByteTerm);
  endtask

  task automatic test_no_idle_burst(input int unsigned target);
    int unsigned stop_at;
    idle_on = 1'b0;
    write_limit(uafa_pkg::CountW'($urandom_range(3, 20)));
    stop_at = sent_count + target;
    while (sent_count < stop_at) send_random_text(24);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_bytes();
    test_accent_folds();
    test_dash_sequences();
    test_cut_sequences();
    test_char_limit();
    test_random_texts(700);
    test_long_text();
    test_no_idle_burst(250);

    settle_idle();
    repeat (20) @(posedge clk_i);
    if (fold_expected.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", fold_expected.size()));

    $display("Sent %0d bytes in %0d texts and checked %0d results,",
             sent_count, texts_done, checked_count);
    $display("with character limits from 0 up to 1023 and random stalls on both sides.");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
